// ----- rtl/ied_pkg.sv -----
package ied_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int CHAR_W      = 8;
	localparam int THR_W       = 7;
	localparam int DIST_W      = 7;

	localparam logic [THR_W-1:0]  THR_RESET = 7'd1;
	localparam logic [DIST_W-1:0] DIST_SAT  = 7'd127;

	// control bits that travel with a second-word character along the row
	typedef struct packed {
		logic valid;
		logic upd;
		logic last;
	} ied_flags_t;

	// first-word load broadcast to every cell
	typedef struct packed {
		logic              wr;
		logic              start;
		logic [CHAR_W-1:0] ch;
	} ied_load_t;

endpackage

// ----- rtl/ied_cell.sv -----
module ied_cell
	import ied_pkg::*;
#(
	parameter int K  = 1,
	parameter int IW = 6,
	parameter int VW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ied_load_t         load,
	input  logic [IW-1:0]     load_idx,
	input  ied_flags_t        flags_i,
	input  logic [CHAR_W-1:0] ch_i,
	input  logic [VW-1:0]     left_i,
	input  logic [VW-1:0]     diag_i,
	output ied_flags_t        flags_o,
	output logic [CHAR_W-1:0] ch_o,
	output logic [VW-1:0]     left_o,
	output logic [VW-1:0]     diag_o
);

	logic [CHAR_W-1:0] fw_q;
	logic [VW-1:0]     dp_q;
	logic              act_q;
	logic              hit;
	logic              match;
	logic [VW-1:0]     up1;
	logic [VW-1:0]     left1;
	logic [VW-1:0]     best;

	assign hit = (load_idx == IW'(K));

	always_comb begin
		match = act_q && (fw_q == ch_i);
		up1   = dp_q + VW'(1);
		left1 = left_i + VW'(1);
		best  = (up1 < left1) ? up1 : left1;
		if (match && (diag_i < best)) begin
			best = diag_i;
		end
	end

	// active flag marks cells inside the stored first word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			flags_o <= '0;
		end else begin
			if (load.wr) begin
				if (load.start) begin
					act_q <= hit;
				end else if (hit) begin
					act_q <= 1'b1;
				end
			end
			if (adv) begin
				flags_o <= flags_i;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.wr && hit) begin
			fw_q <= load.ch;
			dp_q <= VW'(K);
		end
		if (adv) begin
			ch_o   <= ch_i;
			diag_o <= dp_q;
			if (flags_i.valid && act_q && flags_i.upd) begin
				dp_q   <= best;
				left_o <= best;
			end else if (act_q) begin
				left_o <= dp_q;
			end else begin
				left_o <= left_i;
			end
		end
	end

endmodule

// ----- rtl/indel_edit_distance.sv -----
// insertion/deletion edit distance between two byte words
//
// input channel (char_valid / char_stall): one byte per transaction, with
// word_select choosing the word and last_char closing it. first-word bytes
// are stored in a row of MAX_LEN cells; extra bytes are dropped and flagged.
// each second-word byte enters the row as a wavefront that moves one cell
// per cycle while the row is not frozen, so second-word bytes are taken
// back to back, one per cycle. a first-word byte is held off (char_stall)
// until the row has drained and the last second-word byte has left it.
//
// result channel (result_valid / result_stall): one transaction per word
// pair whose second word is closed, registered as its last byte leaves the row.
// a stalled result holds; the whole row freezes and char_stall stays high
// until the result is taken.
//
// threshold_we / threshold_wdata write the match threshold (reset 1).
// reset clears the pair state, the row's token flags and the result valid;
// stored bytes come back only as they are written again.
module indel_edit_distance
	import ied_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  logic              word_select,
	input  logic [CHAR_W-1:0] character,
	input  logic              last_char,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [DIST_W-1:0] distance,
	output logic              within_threshold,
	output logic              overflow,
	input  logic              threshold_we,
	input  logic [THR_W-1:0]  threshold_wdata
);

	// index of a stored byte and count of second-word bytes
	localparam int IW = $clog2(MAX_LEN + 1);
	// row values reach twice MAX_LEN, plus one inside the cell compare
	localparam int VW = $clog2(2 * MAX_LEN + 2);
	localparam int EW = (VW > DIST_W) ? VW : DIST_W;

	// pair state
	logic [IW-1:0]    first_length_q;
	logic [IW-1:0]    second_count_q;
	logic             loading_q;
	logic             ovf_q;
	logic             ovf_pend_q;
	logic [THR_W-1:0] thr_q;

	// token path: entry 0 is the row input, entry k the output of cell k
	ied_flags_t        flags_c [0:MAX_LEN];
	logic [CHAR_W-1:0] ch_c    [0:MAX_LEN];
	logic [VW-1:0]     left_c  [0:MAX_LEN];
	logic [VW-1:0]     diag_c  [0:MAX_LEN];

	ied_load_t     load;
	logic [IW-1:0] load_idx;
	logic [IW-1:0] base_len;
	logic          start;
	logic          full;
	logic          adv;
	logic          busy;
	logic          accept;
	logic          upd;
	logic [EW-1:0] d_ext;

	// the row only moves when the result register can take what comes out
	assign adv        = !(result_valid && result_stall);
	assign char_stall = !adv || (!word_select && busy);
	assign accept     = char_valid && !char_stall;

	always_comb begin
		busy = 1'b0;
		for (int k = 0; k <= MAX_LEN; k++) begin
			busy = busy | flags_c[k].valid;
		end
	end

	// first-word load: a new word starts after a finished or aborted pair
	assign start    = loading_q || (first_length_q == '0);
	assign base_len = start ? '0 : first_length_q;
	assign full     = (base_len >= IW'(MAX_LEN));
	assign load_idx = base_len + IW'(1);

	always_comb begin
		load.wr    = accept && !word_select && !full;
		load.start = start;
		load.ch    = character;
	end

	assign upd = (second_count_q < IW'(MAX_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_length_q <= '0;
			second_count_q <= '0;
			loading_q      <= 1'b0;
			ovf_q          <= 1'b0;
			ovf_pend_q     <= 1'b0;
			thr_q          <= THR_RESET;
			flags_c[0]     <= '0;
		end else begin
			if (threshold_we) begin
				thr_q <= threshold_wdata;
			end
			// second-word byte enters the row, otherwise an empty slot
			if (accept && word_select && loading_q) begin
				flags_c[0] <= '{valid: 1'b1, upd: upd, last: last_char};
			end else if (adv) begin
				flags_c[0] <= '0;
			end
			if (accept && !word_select) begin
				// first-word byte, possibly opening a new pair
				if (!full) begin
					first_length_q <= load_idx;
				end else begin
					first_length_q <= base_len;
				end
				ovf_q <= (start ? 1'b0 : ovf_q) | full;
				if (start || last_char) begin
					second_count_q <= '0;
				end
				loading_q <= last_char;
			end else if (accept && loading_q) begin
				if (last_char) begin
					ovf_pend_q     <= ovf_q | !upd;
					first_length_q <= '0;
					second_count_q <= '0;
					loading_q      <= 1'b0;
					ovf_q          <= 1'b0;
				end else if (upd) begin
					second_count_q <= second_count_q + IW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// column zero of the row is the second-word count itself
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_c[0]   <= character;
			diag_c[0] <= VW'(second_count_q);
			if (upd) begin
				left_c[0] <= VW'(second_count_q) + VW'(1);
			end else begin
				left_c[0] <= VW'(second_count_q);
			end
		end
	end

	for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
		ied_cell #(
			.K  (k),
			.IW (IW),
			.VW (VW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.load     (load),
			.load_idx (load_idx),
			.flags_i  (flags_c[k-1]),
			.ch_i     (ch_c[k-1]),
			.left_i   (left_c[k-1]),
			.diag_i   (diag_c[k-1]),
			.flags_o  (flags_c[k]),
			.ch_o     (ch_c[k]),
			.left_o   (left_c[k]),
			.diag_o   (diag_c[k])
		);
	end

	// inactive cells pass the value through, so the row end carries the
	// entry for the full first word
	assign d_ext = EW'(left_c[MAX_LEN]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			if (adv && flags_c[MAX_LEN].valid && flags_c[MAX_LEN].last) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && flags_c[MAX_LEN].valid && flags_c[MAX_LEN].last) begin
			distance         <= (d_ext > EW'(DIST_SAT)) ? DIST_SAT : d_ext[DIST_W-1:0];
			within_threshold <= (d_ext <= EW'(thr_q));
			overflow         <= ovf_pend_q;
		end
	end

endmodule

// ----- rtl/ied_checker.sv -----
module ied_checker
	import ied_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              char_stall,
	input logic              result_valid,
	input logic              result_stall,
	input logic [DIST_W-1:0] distance,
	input logic              within_threshold,
	input logic              overflow
);

	// a stalled result holds its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(distance) && $stable(within_threshold) &&
			$stable(overflow))
		else $error("stalled result changed");

	// a stalled result freezes the row, so no byte may be taken
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> char_stall)
		else $error("byte taken while result stalled");

	// zero distance is always a close match
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (distance == '0) |-> within_threshold)
		else $error("zero distance outside threshold");

endmodule

bind indel_edit_distance ied_checker u_ied_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.char_stall       (char_stall),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.distance         (distance),
	.within_threshold (within_threshold),
	.overflow         (overflow)
);

// ----- test/indel_edit_distance_test.sv -----
module indel_edit_distance_test;
	import ied_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEF;
	// row drain plus result register, with some margin
	localparam int DRAIN_CYCLES = MAX_LEN + 8;

	// one result transaction as the block should produce it
	typedef struct {
		logic [DIST_W-1:0] dval;
		logic              near;
		logic              ovf;
	} indel_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              char_valid = 1'b0;
	logic              char_stall;
	logic              word_select = 1'b0;
	logic [CHAR_W-1:0] character = '0;
	logic              last_char = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [DIST_W-1:0] distance;
	logic              within_threshold;
	logic              overflow;
	logic              threshold_we = 1'b0;
	logic [THR_W-1:0]  threshold_wdata = '0;

	// predicted distances still waiting for their result transaction
	indel_result_t distance_queue[$];
	int            mismatch_count = 0;

	// idling switches and the long receiver hold-off request
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_req = 1'b0;
	int chars_offered = 0;

	// own copy of the block state
	logic [CHAR_W-1:0] stored_word[MAX_LEN];
	int unsigned       stored_len;
	int unsigned       cost_row[MAX_LEN + 1];
	int unsigned       second_len;
	bit                second_open;
	bit                dropped_seen;
	logic [THR_W-1:0]  close_threshold;

	indel_edit_distance #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.char_valid       (char_valid),
		.char_stall       (char_stall),
		.word_select      (word_select),
		.character        (character),
		.last_char        (last_char),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.distance         (distance),
		.within_threshold (within_threshold),
		.overflow         (overflow),
		.threshold_we     (threshold_we),
		.threshold_wdata  (threshold_wdata)
	);

	always #4 clk = ~clk;

	// forget the current word pair
	function automatic void clear_word_pair();
		stored_len = 0;
		second_len = 0;
		second_open = 1'b0;
		dropped_seen = 1'b0;
	endfunction

	// advance the predicted state by one accepted character transaction
	function automatic void indel_step(bit sel, logic [CHAR_W-1:0] ch, bit last);
		int unsigned   diag;
		int unsigned   up;
		int unsigned   best;
		int unsigned   d;
		indel_result_t r;
		if (!sel) begin
			// a first-word byte after the word was closed starts a new pair
			if (second_open)
				clear_word_pair();
			if (stored_len < MAX_LEN) begin
				stored_word[stored_len] = ch;
				stored_len++;
			end else begin
				dropped_seen = 1'b1;
			end
			if (last) begin
				second_open = 1'b1;
				second_len = 0;
				for (int i = 0; i <= MAX_LEN; i++)
					cost_row[i] = (i <= stored_len) ? i : 0;
			end
			return;
		end
		// second-word byte with no closed first word is ignored
		if (!second_open)
			return;
		if (second_len < MAX_LEN) begin
			diag = cost_row[0];
			second_len++;
			cost_row[0] = second_len;
			for (int i = 1; i <= stored_len; i++) begin
				up = cost_row[i];
				best = up + 1;
				if (cost_row[i - 1] + 1 < best)
					best = cost_row[i - 1] + 1;
				if (stored_word[i - 1] == ch && diag < best)
					best = diag;
				diag = up;
				cost_row[i] = best;
			end
		end else begin
			dropped_seen = 1'b1;
		end
		if (last) begin
			d = cost_row[stored_len];
			r.dval = (d > 127) ? DIST_SAT : d[DIST_W-1:0];
			r.near = (d <= close_threshold);
			r.ovf = dropped_seen;
			distance_queue.push_back(r);
			clear_word_pair();
		end
	endfunction

	// offer one character transaction and predict it once taken
	task automatic send_char(input bit sel, input logic [CHAR_W-1:0] ch, input bit last);
		int gap;
		char_valid <= 1'b1;
		word_select <= sel;
		character <= ch;
		last_char <= last;
		do @(posedge clk); while (char_stall);
		indel_step(sel, ch, last);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random byte: mostly a four-letter alphabet so that matches happen
	function automatic logic [CHAR_W-1:0] pick_char(bit wide);
		if (wide)
			return CHAR_W'($urandom_range(0, 255));
		return 8'h61 + CHAR_W'($urandom_range(0, 3));
	endfunction

	// short words mostly, now and then one near or past the row length
	function automatic int pick_length();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
		return $urandom_range(1, 8);
	endfunction

	task automatic send_word(input bit sel, input int len, input bit wide, input bit close_it);
		for (int i = 0; i < len; i++)
			send_char(sel, pick_char(wide), close_it && (i == len - 1));
		chars_offered += len;
	endtask

	// threshold is written only with the block drained and the row idle
	task automatic write_threshold(input logic [THR_W-1:0] value);
		char_valid <= 1'b0;
		while (distance_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		threshold_we <= 1'b1;
		threshold_wdata <= value;
		@(posedge clk);
		threshold_we <= 1'b0;
		close_threshold = value;
	endtask

	// byte extremes, ignored second-word byte, aborted pair, plain pairs
	task automatic test_directed();
		send_char(1'b1, 8'h41, 1'b1);
		send_char(1'b0, 8'h00, 1'b1);
		send_char(1'b1, 8'h00, 1'b1);
		send_char(1'b0, 8'hFF, 1'b1);
		send_char(1'b1, 8'h00, 1'b1);
		// first word still open: second-word byte is dropped silently
		send_char(1'b0, 8'h41, 1'b0);
		send_char(1'b1, 8'h41, 1'b0);
		send_char(1'b0, 8'h42, 1'b1);
		send_char(1'b1, 8'h42, 1'b0);
		send_char(1'b1, 8'h41, 1'b1);
		// abort: first-word byte in the middle of the second word
		send_char(1'b0, 8'h41, 1'b1);
		send_char(1'b1, 8'h42, 1'b0);
		send_char(1'b0, 8'h43, 1'b1);
		send_char(1'b1, 8'h43, 1'b1);
		// one match at distance threshold + 2
		send_char(1'b0, 8'h61, 1'b0);
		send_char(1'b0, 8'h62, 1'b1);
		send_char(1'b1, 8'h62, 1'b0);
		send_char(1'b1, 8'hAA, 1'b0);
		send_char(1'b1, 8'h55, 1'b1);
	endtask

	// full rows, dropped bytes and a close flag on a dropped byte
	task automatic test_long_words();
		for (int i = 0; i < MAX_LEN; i++)
			send_char(1'b0, 8'h00, i == MAX_LEN - 1);
		for (int i = 0; i < MAX_LEN; i++)
			send_char(1'b1, 8'hFF, i == MAX_LEN - 1);
		send_word(1'b0, MAX_LEN + 2, 1'b0, 1'b1);
		send_word(1'b1, MAX_LEN + 1, 1'b0, 1'b1);
		send_word(1'b0, 4, 1'b1, 1'b1);
		send_word(1'b1, MAX_LEN + 3, 1'b1, 1'b1);
	endtask

	// receiver holds off while pairs keep coming, so the input stalls
	task automatic test_back_pressure();
		hold_req = 1'b1;
		for (int p = 0; p < 4; p++) begin
			send_word(1'b0, $urandom_range(1, 6), 1'b0, 1'b1);
			send_word(1'b1, $urandom_range(1, 6), 1'b0, 1'b1);
		end
	endtask

	// well-formed pairs with random content, plus stray and aborted ones
	task automatic test_random_pairs(input int n_items);
		int start;
		start = chars_offered;
		while (chars_offered - start < n_items) begin
			if ($urandom_range(0, 9) == 0)
				send_char(1'b1, pick_char(1'b1), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0) begin
				send_word(1'b0, pick_length(), $urandom_range(0, 3) == 0, 1'b1);
				send_word(1'b1, $urandom_range(1, 5), 1'b0, 1'b0);
			end
			send_word(1'b0, pick_length(), $urandom_range(0, 3) == 0, 1'b1);
			send_word(1'b1, pick_length(), $urandom_range(0, 3) == 0, 1'b1);
		end
	endtask

	// receiver side: random stall bursts, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				result_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		indel_result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (distance_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: distance %0d within %0b overflow %0b",
						distance, within_threshold, overflow);
			end else begin
				exp_r = distance_queue.pop_front();
				if (distance !== exp_r.dval || within_threshold !== exp_r.near ||
						overflow !== exp_r.ovf) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							exp_r.dval, exp_r.near, exp_r.ovf,
							distance, within_threshold, overflow);
				end
			end
		end
	end

	initial begin
		clear_word_pair();
		close_threshold = THR_RESET;
		for (int i = 0; i < MAX_LEN; i++)
			stored_word[i] = '0;
		for (int i = 0; i <= MAX_LEN; i++)
			cost_row[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold first, then the extremes and random settings
		test_directed();
		write_threshold(7'd64);
		test_long_words();
		test_back_pressure();
		write_threshold(THR_W'($urandom_range(0, 64)));
		test_random_pairs(50);
		write_threshold(7'd0);
		test_random_pairs(50);
		write_threshold(7'd64);
		test_random_pairs(50);
		// last part runs with no idling on either side
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_threshold(THR_W'($urandom_range(0, 64)));
		test_random_pairs(50);

		char_valid <= 1'b0;
		while (distance_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** indel_edit_distance: PASSED **");
		else
			$display("** indel_edit_distance: FAILED **");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#2000000;
		$display("** indel_edit_distance: FAILED **");
		$finish;
	end

endmodule
